// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSTOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSTOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sstod_pkg.sv =====
package sstod_pkg;

  // Depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH = 2;

  // Characters per HH:MM:SS string.
  localparam int unsigned RX_LEN = 8;
  localparam logic [2:0] RX_LAST = 3'(RX_LEN - 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [0:0] OP_TICK = 1'b0;
  localparam logic [0:0] OP_CHAR = 1'b1;

  localparam logic [1:0] STAT_TIME    = 2'd0;
  localparam logic [1:0] STAT_SET_OK  = 2'd1;
  localparam logic [1:0] STAT_SET_BAD = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_SET_OK,
    CMD_SET_BAD
  } cmd_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } back_st_e;

  // Time of day kept as BCD digits.
  typedef struct packed {
    logic [1:0] h_tens;
    logic [3:0] h_ones;
    logic [2:0] m_tens;
    logic [3:0] m_ones;
    logic [2:0] s_tens;
    logic [3:0] s_ones;
  } tod_t;

  typedef struct packed {
    cmd_e kind;
    tod_t tod;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Advance one second with wraps at 60, 60 and 24.
  function automatic tod_t tod_incr(input tod_t t);
    tod_t r;
    r = t;
    if (t.s_ones != 4'd9) begin
      r.s_ones = t.s_ones + 4'd1;
    end else begin
      r.s_ones = 4'd0;
      if (t.s_tens != 3'd5) begin
        r.s_tens = t.s_tens + 3'd1;
      end else begin
        r.s_tens = 3'd0;
        if (t.m_ones != 4'd9) begin
          r.m_ones = t.m_ones + 4'd1;
        end else begin
          r.m_ones = 4'd0;
          if (t.m_tens != 3'd5) begin
            r.m_tens = t.m_tens + 3'd1;
          end else begin
            r.m_tens = 3'd0;
            if (t.h_tens == 2'd2 && t.h_ones == 4'd3) begin
              r.h_tens = 2'd0;
              r.h_ones = 4'd0;
            end else if (t.h_ones == 4'd9) begin
              r.h_tens = t.h_tens + 2'd1;
              r.h_ones = 4'd0;
            end else begin
              r.h_ones = t.h_ones + 4'd1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // ASCII character at a position of HH:MM:SS.
  function automatic logic [7:0] tod_char(input tod_t t, input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = CHAR_ZERO + {6'd0, t.h_tens};
      3'd1: c = CHAR_ZERO + {4'd0, t.h_ones};
      3'd3: c = CHAR_ZERO + {5'd0, t.m_tens};
      3'd4: c = CHAR_ZERO + {4'd0, t.m_ones};
      3'd6: c = CHAR_ZERO + {5'd0, t.s_tens};
      3'd7: c = CHAR_ZERO + {4'd0, t.s_ones};
      default: c = CHAR_COLON;
    endcase
    return c;
  endfunction

endpackage

// ===== src/sstod_cmdq.sv =====
module sstod_cmdq #(
  parameter int unsigned Depth = sstod_pkg::CMD_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sstod_pkg::cmd_t   wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output sstod_pkg::cmd_t   rdata_o,
  output logic              empty_o
);
  import sstod_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/sstod_front.sv =====
module sstod_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic [7:0]        rx_char_i,
  output logic              cmd_push_o,
  output sstod_pkg::cmd_t   cmd_o
);
  import sstod_pkg::*;

  // First seven characters of the set string; the eighth arrives live.
  logic [7:0] rx_store_q [RX_LEN-1];
  logic [2:0] rx_count_q, rx_count_d;
  logic       running_q, running_d;
  logic [7:0] c [RX_LEN];
  logic       digits_ok, range_ok, set_ok, is_last;

  always_comb begin
    for (int i = 0; i < int'(RX_LEN) - 1; i++) begin
      c[i] = rx_store_q[i];
    end
    c[RX_LEN-1] = rx_char_i;
  end

  assign digits_ok = is_digit(c[0]) && is_digit(c[1]) && is_digit(c[3]) &&
                     is_digit(c[4]) && is_digit(c[6]) && is_digit(c[7]);
  assign range_ok  = ((c[0][3:0] < 4'd2) || ((c[0][3:0] == 4'd2) && (c[1][3:0] < 4'd4))) &&
                     (c[3][3:0] < 4'd6) && (c[6][3:0] < 4'd6);
  assign set_ok    = digits_ok && range_ok;
  assign is_last   = (rx_count_q == RX_LAST);

  always_comb begin
    cmd_push_o     = 1'b0;
    cmd_o.kind     = CMD_TICK;
    cmd_o.tod      = '{h_tens: c[0][1:0], h_ones: c[1][3:0], m_tens: c[3][2:0],
                       m_ones: c[4][3:0], s_tens: c[6][2:0], s_ones: c[7][3:0]};
    rx_count_d     = rx_count_q;
    running_d      = running_q;
    if (accept_i) begin
      if (opcode_i == OP_CHAR) begin
        if (is_last) begin
          rx_count_d = '0;
          cmd_push_o = 1'b1;
          cmd_o.kind = set_ok ? CMD_SET_OK : CMD_SET_BAD;
          if (set_ok) begin
            running_d = 1'b1;
          end
        end else begin
          rx_count_d = rx_count_q + 3'd1;
        end
      end else if (running_q) begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= '0;
      running_q  <= 1'b0;
    end else begin
      rx_count_q <= rx_count_d;
      running_q  <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (opcode_i == OP_CHAR) && !is_last) begin
      rx_store_q[rx_count_q] <= rx_char_i;
    end
  end

endmodule

// ===== src/sstod_back.sv =====
module sstod_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sstod_pkg::cmd_t   cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_char_o,
  output logic              last_of_run_o,
  output logic [1:0]        status_o
);
  import sstod_pkg::*;

  back_st_e   state_q, state_d;
  tod_t       tod_q, tod_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_free, out_load, take_cmd;

  assign out_free = !out_valid_q || pop_i;
  assign take_cmd = (state_q == ST_IDLE) && !cmd_empty_i && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_cmd && (cmd_i.kind == CMD_TICK)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (idx_q == RX_LAST)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_pop_o    = 1'b0;
    out_load     = 1'b0;
    tod_d        = tod_q;
    idx_d        = idx_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    case (state_q)
      ST_IDLE: begin
        if (take_cmd) begin
          cmd_pop_o = 1'b1;
          out_load  = 1'b1;
          case (cmd_i.kind)
            CMD_TICK: begin
              tod_d        = tod_incr(tod_q);
              out_char_d   = tod_char(tod_d, 3'd0);
              out_last_d   = 1'b0;
              out_status_d = STAT_TIME;
              idx_d        = 3'd1;
            end
            CMD_SET_OK: begin
              tod_d        = cmd_i.tod;
              out_char_d   = '0;
              out_last_d   = 1'b1;
              out_status_d = STAT_SET_OK;
            end
            default: begin
              out_char_d   = '0;
              out_last_d   = 1'b1;
              out_status_d = STAT_SET_BAD;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_d   = tod_char(tod_q, idx_q);
          out_last_d   = (idx_q == RX_LAST);
          out_status_d = STAT_TIME;
          idx_d        = idx_q + 3'd1;
        end
      end
      default: ;
    endcase
    out_valid_d = out_load ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tod_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tod_q       <= tod_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q   <= out_char_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign status_o      = out_status_q;

endmodule

// ===== src/serial_set_time_of_day_clock.sv =====
// A result shows at the edge where its command leaves the command queue. Each command is
// written to the queue on transfer in and waits there until the back end can take it.
// Input: one transfer per cycle while the command queue has room. The back end is held by
// a running tick for its eight characters (one character per cycle while the result side
// pops) and by a set string for its one status, all through the single output register.
// Reset: asynchronous, active low; clears the time to 00:00:00, stops the clock, empties
// the queue and the output register. Stored set characters are not cleared.
module serial_set_time_of_day_clock #(
  parameter int unsigned CmdDepth = sstod_pkg::CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       opcode_i,
  input  logic [7:0] rx_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o,
  output logic [1:0] status_o
);
  import sstod_pkg::*;

  logic accept;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic res_empty;

  // Transfer in whenever the command queue has a free slot; characters that
  // only fill the set buffer are gated by the same condition to keep full simple.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Front end: collect set characters, validate the string, drop ticks while stopped.
  sstod_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .rx_char_i  (rx_char_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue decouples classification from character output.
  sstod_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back end: hold the time, advance it on ticks, emit HH:MM:SS or a set status.
  sstod_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .pop_i         (pop && !res_empty),
    .empty_o       (res_empty),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

  assign empty = res_empty;

endmodule

// ===== src/sstod_checker.sv =====
`include "assert_macros.svh"

module sstod_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       last_of_run_o,
  input logic [1:0] status_o
);
  import sstod_pkg::*;

  `SSTOD_ASSERT_NOW(a_status_code, !empty, status_o == STAT_TIME || status_o == STAT_SET_OK || status_o == STAT_SET_BAD, "status code out of range")
  `SSTOD_ASSERT_NOW(a_status_shape, !empty && status_o != STAT_TIME, out_char_o == 8'h00 && last_of_run_o, "status result must be zero char and last")
  `SSTOD_ASSERT_NOW(a_time_char, !empty && status_o == STAT_TIME, out_char_o >= CHAR_ZERO && out_char_o <= CHAR_COLON, "time character not a digit or colon")
  `SSTOD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_char_o) && $stable(status_o) && $stable(last_of_run_o), "stalled result changed")

endmodule

bind serial_set_time_of_day_clock sstod_checker u_sstod_checker (.*);

// ===== tb/tb_serial_set_time_of_day_clock.sv =====
`timescale 1ns / 1ps

module tb_serial_set_time_of_day_clock;
  import sstod_pkg::*;

  // Give up after this many cycles without a transfer on either side.
  localparam int unsigned IDLE_LIMIT   = 1000;
  // Cycles to let pass after the last expected result.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Least number of random input transfers per idling phase.
  localparam int unsigned PHASE_ITEMS  = 15;
  // Length of the long result-side hold-off.
  localparam int unsigned HOLD_CYCLES  = 80;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
  } tod_out_t;

  // How a directed row gets its expectation: from the predictor, none at all,
  // a typed status, or a typed HH:MM:SS string.
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_NONE,
    ROW_STATUS,
    ROW_TIME
  } row_kind_e;

  typedef struct packed {
    logic [0:0]  op;
    logic [7:0]  ch;
    row_kind_e   kind;
    logic [1:0]  st;
    logic [63:0] txt;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       full;
  logic       opcode_i  = OP_TICK;
  logic [7:0] rx_char_i = 8'h00;
  logic       empty;
  logic       pop       = 1'b0;
  logic [7:0] out_char_o;
  logic       last_of_run_o;
  logic [1:0] status_o;

  serial_set_time_of_day_clock dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .rx_char_i    (rx_char_i),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o),
    .status_o     (status_o)
  );

  // Predicted clock state, mirrors the block from reset on.
  logic [4:0] tod_hours     = '0;
  logic [5:0] tod_minutes   = '0;
  logic [5:0] tod_seconds   = '0;
  logic       clock_running = 1'b0;
  logic [2:0] rx_fill       = '0;
  logic [7:0] rx_buf [8];

  // Results caused by the latest input, and results still owed by the block.
  tod_out_t step_res [$];
  tod_out_t expected_chars [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int n_items        = 0;
  int n_results      = 0;
  int n_errors       = 0;
  int n_set_ok       = 0;
  int n_set_bad      = 0;
  int n_tick_runs    = 0;

  // Directed part: ignored tick after reset, a set to the last second of the
  // day with junk in both separator slots (0x00 and 0xFF), the full wrap to
  // midnight, an hour-out-of-range set that must leave the time alone, and
  // one more tick to show the clock kept its time.
  dir_row_t dir_rows [19] = '{
    '{OP_TICK, 8'h00,      ROW_NONE,   STAT_TIME,    64'd0},
    '{OP_CHAR, "2",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "3",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, 8'h00,      ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "5",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "9",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, 8'hFF,      ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "5",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "9",        ROW_STATUS, STAT_SET_OK,  64'd0},
    '{OP_TICK, 8'hFF,      ROW_TIME,   STAT_TIME,    "00:00:00"},
    '{OP_CHAR, "2",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "4",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, CHAR_COLON, ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "0",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "0",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, CHAR_COLON, ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "0",        ROW_MODEL,  STAT_TIME,    64'd0},
    '{OP_CHAR, "0",        ROW_STATUS, STAT_SET_BAD, 64'd0},
    '{OP_TICK, 8'h00,      ROW_TIME,   STAT_TIME,    "00:00:01"}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Parse two stored characters as a decimal number below limit.
  function automatic bit digit_pair(input int pos, input int limit, output int val);
    logic [7:0] hi;
    logic [7:0] lo;
    hi  = rx_buf[pos];
    lo  = rx_buf[pos + 1];
    val = 10 * (int'(hi) - int'(CHAR_ZERO)) + (int'(lo) - int'(CHAR_ZERO));
    return hi >= CHAR_ZERO && hi <= CHAR_NINE && lo >= CHAR_ZERO && lo <= CHAR_NINE &&
           val < limit;
  endfunction

  // Apply one input to the predicted clock; leave its results in step_res.
  function automatic void tod_apply_item(input logic [0:0] op, input logic [7:0] ch);
    int h;
    int m;
    int s;
    logic [63:0] txt;
    step_res.delete();
    if (op == OP_CHAR) begin
      rx_buf[rx_fill] = ch;
      if (rx_fill != RX_LAST) begin
        rx_fill++;
        return;
      end
      rx_fill = '0;
      if (digit_pair(0, 24, h) && digit_pair(3, 60, m) && digit_pair(6, 60, s)) begin
        tod_hours     = 5'(h);
        tod_minutes   = 6'(m);
        tod_seconds   = 6'(s);
        clock_running = 1'b1;
        step_res.push_back('{8'h00, 1'b1, STAT_SET_OK});
        n_set_ok++;
      end else begin
        step_res.push_back('{8'h00, 1'b1, STAT_SET_BAD});
        n_set_bad++;
      end
      return;
    end
    if (!clock_running) return;
    if (tod_seconds == 59) begin
      tod_seconds = '0;
      if (tod_minutes == 59) begin
        tod_minutes = '0;
        tod_hours   = (tod_hours == 23) ? 5'd0 : tod_hours + 5'd1;
      end else begin
        tod_minutes++;
      end
    end else begin
      tod_seconds++;
    end
    txt = {CHAR_ZERO + 8'(tod_hours / 10),   CHAR_ZERO + 8'(tod_hours % 10),   CHAR_COLON,
           CHAR_ZERO + 8'(tod_minutes / 10), CHAR_ZERO + 8'(tod_minutes % 10), CHAR_COLON,
           CHAR_ZERO + 8'(tod_seconds / 10), CHAR_ZERO + 8'(tod_seconds % 10)};
    for (int k = 0; k < 8; k++) begin
      step_res.push_back('{txt[63 - 8*k -: 8], k == 7, STAT_TIME});
    end
    n_tick_runs++;
  endfunction

  // Offer one item after a random gap, hold it until the block takes it, then
  // queue what it should produce. Push stays high after the transfer so that
  // back-to-back items never see it lowered and raised in one step.
  task automatic send_item(input logic [0:0] op, input logic [7:0] ch,
                           input row_kind_e kind = ROW_MODEL,
                           input logic [1:0] st = STAT_TIME,
                           input logic [63:0] txt = '0);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    opcode_i  <= op;
    rx_char_i <= ch;
    do @(posedge clk_i); while (full);
    n_items++;
    tod_apply_item(op, ch);
    case (kind)
      ROW_MODEL: begin
        foreach (step_res[k]) expected_chars.push_back(step_res[k]);
      end
      ROW_STATUS: expected_chars.push_back('{8'h00, 1'b1, st});
      ROW_TIME: begin
        for (int k = 0; k < 8; k++) begin
          expected_chars.push_back('{txt[63 - 8*k -: 8], k == 7, STAT_TIME});
        end
      end
      default: ;
    endcase
  endtask

  // Drop push and wait until the block owes nothing, plus a little settling.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A legal HH:MM:SS, biased toward the carries: 09, 19, 23 hours, minute 59
  // and the last seconds of a minute.
  function automatic logic [63:0] valid_time_text();
    int h;
    int m;
    int s;
    logic [7:0] c2;
    logic [7:0] c5;
    case ($urandom_range(0, 3))
      0:       h = 23;
      1:       h = 9;
      2:       h = 19;
      default: h = $urandom_range(0, 23);
    endcase
    m  = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
    s  = ($urandom_range(0, 2) != 0) ? 59 - $urandom_range(0, 2) : $urandom_range(0, 59);
    // Separators are not checked; put any byte there now and then.
    c2 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CHAR_COLON;
    c5 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CHAR_COLON;
    return {CHAR_ZERO + 8'(h / 10), CHAR_ZERO + 8'(h % 10), c2,
            CHAR_ZERO + 8'(m / 10), CHAR_ZERO + 8'(m % 10), c5,
            CHAR_ZERO + 8'(s / 10), CHAR_ZERO + 8'(s % 10)};
  endfunction

  // A set string that must be rejected: a non-digit in a digit slot, or an
  // hour, minute or second out of range.
  function automatic logic [63:0] broken_time_text();
    logic [63:0] t;
    logic [7:0]  c;
    int          pos;
    t = valid_time_text();
    case ($urandom_range(0, 3))
      0: begin
        pos = $urandom_range(0, 5);
        pos = pos + pos / 2;
        if ($urandom_range(0, 1)) begin
          // Hit the neighbors of the digit range.
          c = $urandom_range(0, 1) ? CHAR_ZERO - 8'd1 : CHAR_COLON;
        end else begin
          do c = 8'($urandom); while (c >= CHAR_ZERO && c <= CHAR_NINE);
        end
        t[63 - 8*pos -: 8] = c;
      end
      1: begin
        if ($urandom_range(0, 1)) t[63:48] = {CHAR_ZERO + 8'd2, CHAR_ZERO + 8'($urandom_range(4, 9))};
        else                      t[63:56] = CHAR_ZERO + 8'($urandom_range(3, 9));
      end
      2:       t[39:32] = CHAR_ZERO + 8'($urandom_range(6, 9));
      default: t[15:8]  = CHAR_ZERO + 8'($urandom_range(6, 9));
    endcase
    return t;
  endfunction

  // Send eight characters, first padding out any partial string left by noise.
  task automatic send_set(input logic [63:0] txt);
    int pad;
    pad = (8 - int'(rx_fill)) % 8;
    repeat (pad) send_item(OP_CHAR, 8'($urandom));
    for (int k = 0; k < 8; k++) send_item(OP_CHAR, txt[63 - 8*k -: 8]);
  endtask

  // One random sequence: mostly tick runs and well-formed sets, some rejected
  // sets, and a little stray-character noise.
  task automatic send_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(OP_TICK, 8'($urandom));
    end else if (pick < 75) begin
      send_set(valid_time_text());
    end else if (pick < 90) begin
      send_set(broken_time_text());
    end else begin
      n = $urandom_range(1, 7);
      repeat (n) send_item(OP_CHAR, 8'($urandom));
    end
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // decide pop for the next cycle (long hold first, else random stalls).
  initial begin : result_side
    tod_out_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: result with nothing expected, actual char %h last %b status %0d",
                   $time, out_char_o, last_of_run_o, status_o);
          n_errors++;
        end else begin
          exp_r = expected_chars.pop_front();
          n_results++;
          if (out_char_o !== exp_r.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, exp_r.ch, out_char_o);
            n_errors++;
          end
          if (last_of_run_o !== exp_r.last) begin
            $display("%0t: last_of_run expected %b actual %b", $time, exp_r.last, last_of_run_o);
            n_errors++;
          end
          if (status_o !== exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status_o);
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still expected",
                 $time, quiet, expected_chars.size());
        $display("[serial_set_time_of_day_clock] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 75, 0, 33};
    recv_pct = '{0, 0, 75, 33};

    // Hold reset low from time zero, then release it at a clock edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table with no idling on either side.
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].kind, dir_rows[r].st,
                dir_rows[r].txt);
    end
    wait_drained();

    // Load a time, then hold the result side off for a long stretch while
    // ticks keep coming, so the block fills and stalls its input. Afterward
    // pause the input until every owed result has come.
    send_set(valid_time_text());
    wait_drained();
    hold_left = HOLD_CYCLES;
    repeat (6) send_item(OP_TICK, 8'($urandom));
    wait_drained();

    // Random part in four idling phases; drain between phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_start    = n_items;
      while (n_items - phase_start < PHASE_ITEMS) send_sequence();
      wait_drained();
    end

    // Stop stalling so a stray late result would show up, then settle.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Covered %0d input transfers and %0d results: %0d sets taken, %0d rejected,",
             n_items, n_results, n_set_ok, n_set_bad);
    $display("%0d tick runs, under four idling mixes and one long result-side hold.",
             n_tick_runs);
    if (n_errors == 0) begin
      $display("[serial_set_time_of_day_clock] OK");
    end else begin
      $display("[serial_set_time_of_day_clock] ERROR");
    end
    $finish;
  end

endmodule
